/* design/fp64dp_pkg.sv */
// Shared types, constants and binary64 helper functions of the dot product block.
`default_nettype none
package fp64dp_pkg;

    localparam int LANES  = 16;
    localparam int LANE_W = $clog2(LANES);
    localparam int ADD_STAGES = 6;

    localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
    localparam logic [3:0]  RED_LAST  = 4'd14;

    typedef struct packed {
        logic              sgn;
        logic signed [12:0] e;
        logic [52:0]       mant;
        logic              nan;
        logic              inf;
        logic              zero;
    } t_unp;

    // value prior to rounding: mant * 2^(e-1075), e >= 1
    typedef struct packed {
        logic              sgn;
        logic signed [12:0] e;
        logic [52:0]       m;
        logic              r;
        logic              s;
    } t_rnd;

    typedef struct packed {
        logic              last;
        logic [LANE_W-1:0] lane;
        logic              sgn;
        logic              spec_en;
        logic [63:0]       spec_val;
    } t_mside;

    typedef struct packed {
        logic [63:0]       x;
        logic [63:0]       y;
        logic              last;
        logic [LANE_W-1:0] lane;
    } t_mul0;

    typedef struct packed {
        t_mside            side;
        logic signed [12:0] ex;
        logic signed [12:0] ey;
        logic [52:0]       mx;
        logic [52:0]       my;
        logic [5:0]        lzx;
        logic [5:0]        lzy;
    } t_mul1;

    typedef struct packed {
        t_mside            side;
        logic signed [12:0] esum;
        logic [52:0]       ma;
        logic [52:0]       mb;
    } t_mul2;

    typedef struct packed {
        t_mside            side;
        logic signed [12:0] esum;
        logic [51:0]       hh;
        logic [52:0]       hl;
        logic [52:0]       lh;
        logic [53:0]       ll;
    } t_mul3;

    typedef struct packed {
        t_mside            side;
        logic signed [12:0] esum;
        logic [105:0]      p;
    } t_mul4;

    typedef struct packed {
        t_mside side;
        t_rnd   rnd;
    } t_mnorm;

    typedef struct packed {
        logic        sgn;
        logic        spec_en;
        logic [63:0] spec_val;
        logic        zero_sgn;
    } t_aside;

    typedef struct packed {
        t_aside             side;
        logic signed [12:0] ebig;
        logic signed [12:0] d;
        logic [52:0]        mbig;
        logic [52:0]        msml;
        logic               sub;
    } t_add1;

    typedef struct packed {
        t_aside             side;
        logic signed [12:0] ebig;
        logic [55:0]        bigx;
        logic [55:0]        al;
        logic               sub;
    } t_add2;

    typedef struct packed {
        t_aside             side;
        logic signed [12:0] ebig;
        logic [56:0]        sum;
    } t_add3;

    typedef struct packed {
        t_aside             side;
        logic signed [12:0] ebig;
        logic [56:0]        sum;
        logic [5:0]         lz;
    } t_add4;

    typedef struct packed {
        t_aside side;
        logic   zero;
        t_rnd   rnd;
    } t_add5;

    typedef struct packed {
        logic              v;
        logic              wr;
        logic              out;
        logic [LANE_W-1:0] dst;
    } t_ctl;

    typedef struct packed {
        logic [LANE_W-1:0] dst;
        logic [LANE_W-1:0] src_a;
        logic [LANE_W-1:0] src_b;
        logic              to_out;
    } t_redop;

    function automatic t_unp unpack(input logic [63:0] v);
        t_unp u;
        u.sgn  = v[63];
        u.nan  = (v[62:52] == 11'h7ff) && (v[51:0] != 52'd0);
        u.inf  = (v[62:52] == 11'h7ff) && (v[51:0] == 52'd0);
        u.zero = (v[62:0] == 63'd0);
        u.e    = (v[62:52] == 11'd0) ? 13'sd1 : $signed({2'b00, v[62:52]});
        u.mant = {(v[62:52] != 11'd0), v[51:0]};
        return u;
    endfunction

    function automatic logic [5:0] lzc53(input logic [52:0] m);
        logic [5:0] n;
        n = 6'd53;
        for (int i = 0; i < 53; i++) begin
            if (m[i]) n = 6'(52 - i);
        end
        return n;
    endfunction

    function automatic logic [5:0] lzc57(input logic [56:0] m);
        logic [5:0] n;
        n = 6'd57;
        for (int i = 0; i < 57; i++) begin
            if (m[i]) n = 6'(56 - i);
        end
        return n;
    endfunction

    // round to nearest even and pack, overflow goes to infinity
    function automatic logic [63:0] round_pack(input t_rnd x);
        logic               inc;
        logic [53:0]        mr;
        logic signed [12:0] ef;
        logic [63:0]        res;
        inc = x.r & (x.s | x.m[0]);
        mr  = {1'b0, x.m} + {53'd0, inc};
        ef  = x.e;
        if (mr[53]) begin
            mr = mr >> 1;
            ef = x.e + 13'sd1;
        end
        if (ef >= 13'sd2047) begin
            res = {x.sgn, 11'h7ff, 52'd0};
        end else begin
            res = {x.sgn, (mr[52] ? ef[10:0] : 11'd0), mr[51:0]};
        end
        return res;
    endfunction

    // fixed reduction order: three column passes, then the pair tree
    function automatic t_redop red_op(input logic [3:0] step);
        t_redop o;
        o.to_out = 1'b0;
        o.dst    = {2'b00, step[1:0]};
        o.src_a  = {2'b00, step[1:0]};
        o.src_b  = {2'b00, step[1:0]};
        case (step)
            4'd0, 4'd1, 4'd2, 4'd3: begin
                o.src_b = {2'b01, step[1:0]};
            end
            4'd4, 4'd5, 4'd6, 4'd7: begin
                o.src_b = {2'b10, step[1:0]};
            end
            4'd8, 4'd9, 4'd10, 4'd11: begin
                o.src_b = {2'b11, step[1:0]};
            end
            4'd12: begin
                o.dst = 4'd0; o.src_a = 4'd0; o.src_b = 4'd2;
            end
            4'd13: begin
                o.dst = 4'd1; o.src_a = 4'd1; o.src_b = 4'd3;
            end
            default: begin
                o.dst = 4'd0; o.src_a = 4'd0; o.src_b = 4'd1; o.to_out = 1'b1;
            end
        endcase
        return o;
    endfunction

endpackage
`default_nettype wire

/* design/fp64_dot_product_16lane.sv */
// Streaming binary64 dot product with 16 interleaved lane accumulators.
//
// Input channel (s): one request carries x, y and tlast for the final pair.
// Output channel (m): one request per vector, the rounded dot product.
// Every pair passes a 7-stage multiplier, then reads its lane accumulator
// from a two-port lane memory, goes through a 6-stage adder (operand
// register plus five stages) and writes the sum back. Lanes rotate modulo
// 16, so a lane comes back well after its previous write: one pair is taken
// every cycle while a vector streams.
// On tlast the same adder and lane memory run a 15-step reduction, held by
// a scoreboard on lanes in flight. During the reduction the next vector fills
// the multiplier and then waits with tready low until the reduction is done.
// After the reduction the lane valid bits drop, so every lane reads +0.0.
// The result sits in an output register; while the receiver stalls, input
// keeps flowing, and only the final step of the next reduction waits.
// Reset (synchronous, active low) empties all stages and marks all lanes
// as +0.0, lane counter back to 0.
`default_nettype none
module fp64_dot_product_16lane (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [127:0]  i_s_tdata,   // [63:0] x_value, [127:64] y_value
    input  wire logic          i_s_tlast,   // last_element
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [63:0]        o_m_tdata    // [63:0] dot_value
);

    localparam int LW = fp64dp_pkg::LANE_W;
    localparam int AS = fp64dp_pkg::ADD_STAGES;
    localparam int LANES_IDX = fp64dp_pkg::LANES;

    // multiplier pipeline
    fp64dp_pkg::t_mul0  r_m0, n_m0;
    fp64dp_pkg::t_mul1  r_m1, n_m1;
    fp64dp_pkg::t_mul2  r_m2, n_m2;
    fp64dp_pkg::t_mul3  r_m3, n_m3;
    fp64dp_pkg::t_mul4  r_m4, n_m4;
    fp64dp_pkg::t_mnorm r_m5, n_m5;
    fp64dp_pkg::t_mnorm r_m6, n_m6;
    logic [6:0]         r_mv;
    logic               adv;
    logic [LW-1:0]      r_lane;
    fp64dp_pkg::t_unp   ux, uy;
    logic               m_nan, m_inf, m_zero, m_sgn;
    logic signed [12:0] m_sh_t;
    logic [5:0]         m_sh;
    logic [117:0]       m_wide;
    logic [63:0]        mul_prod;

    // lane memory and issue
    logic [63:0]        r_mem [LANES_IDX];
    logic [fp64dp_pkg::LANES-1:0] r_lane_vld;
    logic [63:0]        r_rda, r_rdb;
    logic               r_rva, r_rvb, r_racc;
    logic [63:0]        r_rprod;
    logic [LW-1:0]      rd_a, rd_b;
    fp64dp_pkg::t_ctl   r_ctl [AS];
    fp64dp_pkg::t_ctl   n_ctl;
    fp64dp_pkg::t_redop op;
    logic               r_busy, r_seq_done;
    logic [3:0]         r_step;
    logic               haz_acc, haz_a, haz_b;
    logic               issue_acc, issue_seq;
    fp64dp_pkg::t_ctl   wb;
    logic               wb_wr, done;

    // adder pipeline
    fp64dp_pkg::t_add1  r_a1, n_a1;
    fp64dp_pkg::t_add2  r_a2, n_a2;
    fp64dp_pkg::t_add3  r_a3, n_a3;
    fp64dp_pkg::t_add4  r_a4, n_a4;
    fp64dp_pkg::t_add5  r_a5, n_a5;
    logic [63:0]        opa, opb;
    fp64dp_pkg::t_unp   ua, ub, ubig, usml;
    logic               a_nan, a_inf, a_isgn, a_swap;
    logic [5:0]         a_dsh, a_nsh;
    logic [119:0]       a_wide;
    logic [56:0]        a_t;
    logic [63:0]        add_res;

    logic               r_out_valid;
    logic [63:0]        r_out_data;

    // ---------------- multiplier ----------------
    always_comb begin
        n_m0.x    = i_s_tdata[63:0];
        n_m0.y    = i_s_tdata[127:64];
        n_m0.last = i_s_tlast;
        n_m0.lane = r_lane;

        ux     = fp64dp_pkg::unpack(r_m0.x);
        uy     = fp64dp_pkg::unpack(r_m0.y);
        m_sgn  = ux.sgn ^ uy.sgn;
        m_nan  = ux.nan | uy.nan | (ux.inf & uy.zero) | (uy.inf & ux.zero);
        m_inf  = ux.inf | uy.inf;
        m_zero = ux.zero | uy.zero;
        n_m1.side.last    = r_m0.last;
        n_m1.side.lane    = r_m0.lane;
        n_m1.side.sgn     = m_sgn;
        n_m1.side.spec_en = m_nan | m_inf | m_zero;
        n_m1.side.spec_val = m_nan ? fp64dp_pkg::CANON_NAN :
                             m_inf ? {m_sgn, 11'h7ff, 52'd0} : {m_sgn, 63'd0};
        n_m1.ex  = ux.e;
        n_m1.ey  = uy.e;
        n_m1.mx  = ux.mant;
        n_m1.my  = uy.mant;
        n_m1.lzx = fp64dp_pkg::lzc53(ux.mant);
        n_m1.lzy = fp64dp_pkg::lzc53(uy.mant);

        // normalize subnormal inputs
        n_m2.side = r_m1.side;
        n_m2.ma   = r_m1.mx << r_m1.lzx;
        n_m2.mb   = r_m1.my << r_m1.lzy;
        n_m2.esum = r_m1.ex - $signed({7'd0, r_m1.lzx})
                  + r_m1.ey - $signed({7'd0, r_m1.lzy});

        // partial products, 26-bit upper and 27-bit lower halves
        n_m3.side = r_m2.side;
        n_m3.esum = r_m2.esum;
        n_m3.hh   = r_m2.ma[52:27] * r_m2.mb[52:27];
        n_m3.hl   = r_m2.ma[52:27] * r_m2.mb[26:0];
        n_m3.lh   = r_m2.ma[26:0]  * r_m2.mb[52:27];
        n_m3.ll   = r_m2.ma[26:0]  * r_m2.mb[26:0];

        n_m4.side = r_m3.side;
        n_m4.esum = r_m3.esum;
        n_m4.p    = {r_m3.hh, 54'd0} + ({53'd0, r_m3.hl} << 27)
                  + ({53'd0, r_m3.lh} << 27) + {52'd0, r_m3.ll};

        n_m5.side    = r_m4.side;
        n_m5.rnd.sgn = r_m4.side.sgn;
        if (r_m4.p[105]) begin
            n_m5.rnd.m = r_m4.p[105:53];
            n_m5.rnd.r = r_m4.p[52];
            n_m5.rnd.s = |r_m4.p[51:0];
            n_m5.rnd.e = r_m4.esum - 13'sd1022;
        end else begin
            n_m5.rnd.m = r_m4.p[104:52];
            n_m5.rnd.r = r_m4.p[51];
            n_m5.rnd.s = |r_m4.p[50:0];
            n_m5.rnd.e = r_m4.esum - 13'sd1023;
        end

        // shift into the subnormal range when the exponent is too small
        n_m6   = r_m5;
        m_sh_t = 13'sd1 - r_m5.rnd.e;
        m_sh   = (m_sh_t > 13'sd63) ? 6'd63 : m_sh_t[5:0];
        m_wide = {r_m5.rnd.m, r_m5.rnd.r, 64'd0} >> m_sh;
        if (r_m5.rnd.e < 13'sd1) begin
            n_m6.rnd.m = m_wide[117:65];
            n_m6.rnd.r = m_wide[64];
            n_m6.rnd.s = r_m5.rnd.s | (|m_wide[63:0]);
            n_m6.rnd.e = 13'sd1;
        end

        mul_prod = r_m6.side.spec_en ? r_m6.side.spec_val
                                     : fp64dp_pkg::round_pack(r_m6.rnd);
    end

    // ---------------- issue and scoreboard ----------------
    always_comb begin
        op      = fp64dp_pkg::red_op(r_step);
        haz_acc = 1'b0;
        haz_a   = 1'b0;
        haz_b   = 1'b0;
        for (int k = 0; k < AS; k++) begin
            if (r_ctl[k].v && r_ctl[k].wr) begin
                if (r_ctl[k].dst == r_m6.side.lane) haz_acc = 1'b1;
                if (r_ctl[k].dst == op.src_a)       haz_a   = 1'b1;
                if (r_ctl[k].dst == op.src_b)       haz_b   = 1'b1;
            end
        end
        issue_acc = r_mv[6] && !r_busy && !haz_acc;
        issue_seq = r_busy && !r_seq_done && !haz_a && !haz_b
                    && !(op.to_out && r_out_valid);
        adv        = !r_mv[6] || issue_acc;
        o_s_tready = adv;

        rd_a = r_busy ? op.src_a : r_m6.side.lane;
        rd_b = op.src_b;

        n_ctl.v   = issue_acc || issue_seq;
        n_ctl.wr  = issue_acc || (issue_seq && !op.to_out);
        n_ctl.out = issue_seq && op.to_out;
        n_ctl.dst = r_busy ? op.dst : r_m6.side.lane;

        wb    = r_ctl[AS-1];
        wb_wr = wb.v && wb.wr;
        done  = wb.v && wb.out;
    end

    // ---------------- adder ----------------
    always_comb begin
        opa = r_rva ? r_rda : 64'd0;
        opb = r_racc ? r_rprod : (r_rvb ? r_rdb : 64'd0);

        ua     = fp64dp_pkg::unpack(opa);
        ub     = fp64dp_pkg::unpack(opb);
        a_nan  = ua.nan | ub.nan | (ua.inf & ub.inf & (ua.sgn != ub.sgn));
        a_inf  = ua.inf | ub.inf;
        a_isgn = ua.inf ? ua.sgn : ub.sgn;
        a_swap = {ub.e, ub.mant} > {ua.e, ua.mant};
        ubig   = a_swap ? ub : ua;
        usml   = a_swap ? ua : ub;
        n_a1.side.sgn      = ubig.sgn;
        n_a1.side.spec_en  = a_nan | a_inf;
        n_a1.side.spec_val = a_nan ? fp64dp_pkg::CANON_NAN : {a_isgn, 11'h7ff, 52'd0};
        n_a1.side.zero_sgn = ua.sgn & ub.sgn;
        n_a1.ebig = ubig.e;
        n_a1.d    = ubig.e - usml.e;
        n_a1.mbig = ubig.mant;
        n_a1.msml = usml.mant;
        n_a1.sub  = ua.sgn ^ ub.sgn;

        // align the smaller operand, fold shifted-out bits into sticky
        a_dsh  = (r_a1.d > 13'sd63) ? 6'd63 : r_a1.d[5:0];
        a_wide = {r_a1.msml, 67'd0} >> a_dsh;
        n_a2.side = r_a1.side;
        n_a2.ebig = r_a1.ebig;
        n_a2.bigx = {r_a1.mbig, 3'b000};
        n_a2.al   = {a_wide[119:65], a_wide[64] | (|a_wide[63:0])};
        n_a2.sub  = r_a1.sub;

        n_a3.side = r_a2.side;
        n_a3.ebig = r_a2.ebig;
        n_a3.sum  = r_a2.sub ? ({1'b0, r_a2.bigx} - {1'b0, r_a2.al})
                             : ({1'b0, r_a2.bigx} + {1'b0, r_a2.al});

        n_a4.side = r_a3.side;
        n_a4.ebig = r_a3.ebig;
        n_a4.sum  = r_a3.sum;
        n_a4.lz   = fp64dp_pkg::lzc57(r_a3.sum);

        // normalize left, stopping at the subnormal boundary
        a_nsh = ($signed({7'd0, r_a4.lz}) < r_a4.ebig) ? r_a4.lz : r_a4.ebig[5:0];
        a_t   = r_a4.sum << a_nsh;
        n_a5.side    = r_a4.side;
        n_a5.zero    = (r_a4.sum == 57'd0);
        n_a5.rnd.sgn = r_a4.side.sgn;
        n_a5.rnd.m   = a_t[56:4];
        n_a5.rnd.r   = a_t[3];
        n_a5.rnd.s   = |a_t[2:0];
        n_a5.rnd.e   = r_a4.ebig + 13'sd1 - $signed({7'd0, a_nsh});

        add_res = r_a5.side.spec_en ? r_a5.side.spec_val :
                  r_a5.zero ? {r_a5.side.zero_sgn, 63'd0} :
                  fp64dp_pkg::round_pack(r_a5.rnd);
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv        <= '0;
            r_lane      <= '0;
            r_busy      <= 1'b0;
            r_seq_done  <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_lane_vld  <= '0;
            for (int k = 0; k < AS; k++) begin
                r_ctl[k] <= '0;
            end
        end else begin
            if (adv) begin
                r_mv <= {r_mv[5:0], i_s_tvalid};
                if (i_s_tvalid) begin
                    r_lane <= i_s_tlast ? '0 : r_lane + 1'b1;
                end
            end
            r_ctl[0] <= n_ctl;
            for (int k = 1; k < AS; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
            if (issue_acc && r_m6.side.last) begin
                r_busy     <= 1'b1;
                r_seq_done <= 1'b0;
                r_step     <= '0;
            end
            if (issue_seq) begin
                if (r_step == fp64dp_pkg::RED_LAST) begin
                    r_seq_done <= 1'b1;
                end else begin
                    r_step <= r_step + 4'd1;
                end
            end
            if (wb_wr) begin
                r_lane_vld[wb.dst] <= 1'b1;
            end
            // drop all lanes back to +0.0 once the sum leaves
            if (done) begin
                r_busy      <= 1'b0;
                r_lane_vld  <= '0;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m0 <= n_m0;
            r_m1 <= n_m1;
            r_m2 <= n_m2;
            r_m3 <= n_m3;
            r_m4 <= n_m4;
            r_m5 <= n_m5;
            r_m6 <= n_m6;
        end
        r_rprod <= mul_prod;
        r_racc  <= issue_acc;
        r_rva   <= r_lane_vld[rd_a];
        r_rvb   <= r_lane_vld[rd_b];
        r_a1    <= n_a1;
        r_a2    <= n_a2;
        r_a3    <= n_a3;
        r_a4    <= n_a4;
        r_a5    <= n_a5;
        if (done) begin
            r_out_data <= add_res;
        end
    end

    // lane memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wb_wr) begin
            r_mem[wb.dst] <= add_res;
        end
        r_rda <= r_mem[rd_a];
        r_rdb <= r_mem[rd_b];
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // ---------------- assertions ----------------
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue_acc && wb_wr) |-> (wb.dst != r_m6.side.lane))
        else $error("accumulate read collides with lane write-back");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> !r_out_valid)
        else $error("reduction result overwrites a pending result");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> (r_busy && r_seq_done))
        else $error("reduction result without an active reduction");

endmodule
`default_nettype wire

/* bench/fp64_dot_product_16lane_tb.sv */
// Self-checking bench for the 16-lane binary64 dot product stream block.
`timescale 1ns / 100ps
module fp64_dot_product_16lane_tb;

    localparam logic [63:0] EXP_ALL  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] FRAC_ALL = 64'h000F_FFFF_FFFF_FFFF;

    // Dot product predictor plus the queue of sums still owed by the block.
    class dot_scoreboard;
        real         lane_acc[fp64dp_pkg::LANES];
        int unsigned next_lane;
        logic [63:0] sums_due[$];
        int unsigned errors;

        function new();
            for (int k = 0; k < fp64dp_pkg::LANES; k++) lane_acc[k] = 0.0;
            next_lane = 0;
            errors    = 0;
        endfunction

        function logic [63:0] reduce_acc();
            real         col[4];
            real         total;
            logic [63:0] bits;
            for (int j = 0; j < 4; j++) begin
                col[j] = ((lane_acc[j] + lane_acc[4+j]) + lane_acc[8+j]) + lane_acc[12+j];
            end
            total = (col[0] + col[2]) + (col[1] + col[3]);
            bits  = $realtobits(total);
            if ((bits & EXP_ALL) == EXP_ALL && (bits & FRAC_ALL) != 0) begin
                bits = fp64dp_pkg::CANON_NAN;
            end
            return bits;
        endfunction

        function void note_pair(logic [63:0] x, logic [63:0] y, logic last);
            real prod;
            prod = $bitstoreal(x) * $bitstoreal(y);
            lane_acc[next_lane] = lane_acc[next_lane] + prod;
            next_lane = (next_lane + 1) % fp64dp_pkg::LANES;
            if (last) begin
                sums_due.push_back(reduce_acc());
                for (int k = 0; k < fp64dp_pkg::LANES; k++) lane_acc[k] = 0.0;
                next_lane = 0;
            end
        endfunction

        function void check_sum(logic [63:0] got);
            logic [63:0] want;
            if (sums_due.size() == 0) begin
                $display("%0t: unexpected dot_value expected none actual %h", $time, got);
                errors++;
            end else begin
                want = sums_due.pop_front();
                if (got !== want) begin
                    $display("%0t: dot_value expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [127:0] i_s_tdata;   // [63:0] x_value, [127:64] y_value
    logic         i_s_tlast;   // last_element
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [63:0]  o_m_tdata;   // [63:0] dot_value

    dot_scoreboard sb;
    bit            calm;   // no idling on either side

    fp64_dot_product_16lane u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        sb = new();
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tlast  = 1'b0;
        i_m_tready = 1'b0;
        calm       = 1'b0;
    end

    // Sample both channels on the edge, before the edge's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_pair(i_s_tdata[63:0], i_s_tdata[127:64], i_s_tlast);
            if (o_m_tvalid && i_m_tready) sb.check_sum(o_m_tdata);
        end
    end

    // Receiver: random stall bursts until the calm tail.
    initial begin
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    function automatic logic [63:0] pick_fp();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: ;  // raw pattern: any class, any bit
            1: v[62:52] = 11'd0;                              // subnormal or zero
            2: case ($urandom_range(0, 5))
                   0: v = {v[63], 63'd0};
                   1: v = {v[63], 11'h7ff, 52'd0};
                   2: v = {v[63], 11'h7ff, v[51:0] | 52'd1};
                   3: v = {v[63], 11'h7fe, 52'hF_FFFF_FFFF_FFFF};
                   4: v = {v[63], 11'd0, 52'd1};
                   default: v = {v[63], 11'd1, 52'd0};
               endcase
            3: v[62:52] = 11'(1023 + $urandom_range(0, 4) - 2);  // near one, heavy cancellation
            default: v[62:52] = 11'(1023 + $urandom_range(0, 80) - 40);
        endcase
        return v;
    endfunction

    task automatic send_pair(logic [63:0] x, logic [63:0] y, logic last);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {y, x};
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic send_vector(int unsigned len);
        for (int unsigned k = 0; k < len; k++) send_pair(pick_fp(), pick_fp(), k == len - 1);
    endtask

    localparam logic [63:0] ONE    = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] INF    = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] NINF   = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] NZERO  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] FMAX   = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SUBMIN = 64'h0000_0000_0000_0001;
    localparam logic [63:0] SNAN   = 64'hFFF0_0000_0000_0ABC;

    initial begin
        int unsigned sent;
        int unsigned len;
        #1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-element vectors: product added to +0.0 lanes
        send_pair(NZERO, ONE, 1'b1);
        send_pair(INF, 64'd0, 1'b1);           // invalid product gives NaN
        send_pair(SNAN, ONE, 1'b1);            // NaN payload dropped
        send_pair(FMAX, FMAX, 1'b1);           // overflow to infinity
        send_pair(SUBMIN, 64'h3FE0_0000_0000_0000, 1'b1);  // ties to even at the bottom
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1);
        // infinities of both signs in different lanes
        send_pair(INF, ONE, 1'b0);
        send_pair(NINF, ONE, 1'b1);
        // length not a multiple of 16: untouched lanes stay zero
        send_pair(FMAX, ONE, 1'b0);
        send_pair(FMAX, ONE, 1'b0);
        send_pair(64'h0010_0000_0000_0000, NZERO, 1'b1);
        send_vector(16);
        send_vector(17);
        sent = 44;

        while (sent < 650) begin
            if (sent > 560) calm = 1'b1;
            case ($urandom_range(0, 3))
                0: len = 16 * $urandom_range(1, 3);
                1: len = $urandom_range(1, 4);
                default: len = $urandom_range(1, 40);
            endcase
            send_vector(len);
            sent += len;
        end
        i_s_tvalid <= 1'b0;
        i_s_tlast  <= 1'b0;

        @(posedge i_clk);
        while (sb.sums_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.sums_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule
